### sv/assert_macros.svh
// Assertion macros used by quaternion_nlerp.
// Each macro expands to a concurrent assertion, or to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QNL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define QNL_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define QNL_ASSERT(label, clk, rst_n, prop)
`define QNL_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

### sv/qnl_pkg.sv
// Shared constants and types of the quaternion nlerp pipeline.
// Used by every module of the block; depends on nothing.
package qnl_pkg;
  localparam int unsigned BlendOne   = 32768;
  localparam int unsigned NumLanes   = 4;
  localparam int unsigned MagW       = 31;
  localparam int unsigned SumW       = 63;
  localparam int unsigned ResW       = 64;
  localparam int unsigned RootW      = 32;
  localparam int unsigned QW         = 15;
  localparam int unsigned RemW       = 48;
  localparam int unsigned SqrtStages = 16;
  localparam int unsigned SqrtPer    = 2;
  localparam int unsigned DivStages  = 5;
  localparam int unsigned DivPer     = 3;

  typedef logic [MagW-1:0] mag_t;

  // Per-item data that rides along the root and divide stages.
  typedef struct packed {
    mag_t [NumLanes-1:0] m;
    logic [NumLanes-1:0] sgn;
    logic                zero;
  } lanes_t;
endpackage

### sv/quaternion_nlerp.sv
// Quaternion normalized linear interpolation, fully pipelined.
// Input channel: in_valid_i / in_stall_o with start, end and blend fields.
// Output channel: out_valid_o / out_stall_i with the normalized quaternion
// in Q2.14 and a zero_length flag that forces all components to zero.
// Each word accepted produces exactly one result word, in order.
// From acceptance to the output register a word passes 8 front stages
// (dot product, blend, scaling, squares), 16 square root stages at two
// root bits each, 6 divide stages, and the output register. Throughput is
// one word per cycle when not stalled; the whole pipeline moves on one enable.
// When the output register holds a word and out_stall_i is high, every stage
// holds and in_stall_o goes high in the same cycle; nothing is lost or
// repeated. While the output register is empty the block never stalls.
// Reset clears all valid bits; no result is presented until new words
// have travelled the full pipeline.
// Depends on qnl_pkg, qnl_front, qnl_sqrt, qnl_div and assert_macros.svh.
`include "assert_macros.svh"
module quaternion_nlerp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] start_w_i,
  input  logic signed [15:0] start_x_i,
  input  logic signed [15:0] start_y_i,
  input  logic signed [15:0] start_z_i,
  input  logic signed [15:0] end_w_i,
  input  logic signed [15:0] end_x_i,
  input  logic signed [15:0] end_y_i,
  input  logic signed [15:0] end_z_i,
  input  logic [15:0]        blend_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] out_w_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic signed [15:0] out_z_o,
  output logic               zero_length_o
);
  logic adv;
  logic signed [15:0] s_in [4], e_in [4];

  logic                      f_valid, r_valid, d_valid;
  qnl_pkg::lanes_t           f_lanes, r_lanes;
  logic [qnl_pkg::SumW-1:0]  f_sum;
  logic [qnl_pkg::RootW-1:0] r_root;
  logic [qnl_pkg::QW-1:0]    d_q [4];
  logic [3:0]                d_sgn;
  logic                      d_zero;

  logic               out_valid_q;
  logic signed [15:0] out_q [4];
  logic signed [15:0] out_d [4];
  logic               zero_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  assign s_in[0] = start_w_i;
  assign s_in[1] = start_x_i;
  assign s_in[2] = start_y_i;
  assign s_in[3] = start_z_i;
  assign e_in[0] = end_w_i;
  assign e_in[1] = end_x_i;
  assign e_in[2] = end_y_i;
  assign e_in[3] = end_z_i;

  qnl_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .s_i     (s_in),
    .e_i     (e_in),
    .blend_i (blend_i),
    .valid_o (f_valid),
    .lanes_o (f_lanes),
    .sum_o   (f_sum)
  );

  qnl_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (f_valid),
    .lanes_i (f_lanes),
    .sum_i   (f_sum),
    .valid_o (r_valid),
    .lanes_o (r_lanes),
    .root_o  (r_root)
  );

  qnl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (r_valid),
    .lanes_i (r_lanes),
    .root_i  (r_root),
    .valid_o (d_valid),
    .q_o     (d_q),
    .sgn_o   (d_sgn),
    .zero_o  (d_zero)
  );

  always_comb begin
    logic [15:0] qx;
    for (int i = 0; i < 4; i++) begin
      qx = {1'b0, d_q[i]};
      if (d_zero) begin
        out_d[i] = '0;
      end else begin
        out_d[i] = d_sgn[i] ? $signed(-qx) : $signed(qx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q  <= out_d;
      zero_q <= d_zero;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_w_o       = out_q[0];
  assign out_x_o       = out_q[1];
  assign out_y_o       = out_q[2];
  assign out_z_o       = out_q[3];
  assign zero_length_o = zero_q;

  `QNL_ASSERT(a_zero_out, clk_i, rst_ni, (out_valid_o && zero_length_o) |-> (out_w_o == 16'sd0 && out_x_o == 16'sd0 && out_y_o == 16'sd0 && out_z_o == 16'sd0))
  `QNL_ASSERT(a_range, clk_i, rst_ni, out_valid_o |-> (out_w_o <= 16'sd16384 && out_w_o >= -16'sd16384 && out_x_o <= 16'sd16384 && out_x_o >= -16'sd16384))
  `QNL_ASSERT(a_ready_empty, clk_i, rst_ni, !out_valid_q |-> !in_stall_o)
  `QNL_ASSERT_NEXT(a_hold, clk_i, rst_ni, in_stall_o, $stable(out_w_o) && $stable(zero_length_o))
endmodule

### sv/qnl_front.sv
// Front end: dot product, short-path choice, blend, scaling and sum of squares.
// Depends on qnl_pkg. Eight register stages, all moved by one enable.
module qnl_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     valid_i,
  input  logic signed [15:0]       s_i [4],
  input  logic signed [15:0]       e_i [4],
  input  logic [15:0]              blend_i,
  output logic                     valid_o,
  output qnl_pkg::lanes_t          lanes_o,
  output logic [qnl_pkg::SumW-1:0] sum_o
);
  logic [7:0] v_q;

  logic signed [15:0] s1_q [4], e1_q [4], s2_q [4], e2_q [4];
  logic signed [31:0] p1_q [4];
  logic [15:0]        t1_q, t2_q;
  logic               neg2_q, neg3_q;
  logic signed [33:0] a3_q [4], b3_q [4];
  qnl_pkg::mag_t      mag4_q [4], mag5_q [4];
  logic [3:0]         sgn4_q, sgn5_q, sgn6_q, sgn7_q;
  logic [4:0]         k5_q;
  logic               zero5_q, zero6_q, zero7_q;
  qnl_pkg::mag_t      m6_q [4], m7_q [4];
  logic [61:0]        sq7_q [4];
  qnl_pkg::lanes_t    lanes_q;
  logic [qnl_pkg::SumW-1:0] sum_q;

  logic [15:0]        t_d;
  logic               neg_d;
  logic signed [33:0] a_d [4], b_d [4];
  qnl_pkg::mag_t      mag_d [4];
  logic [3:0]         sgn_d;
  qnl_pkg::mag_t      big_d;
  logic [4:0]         k_d;
  logic [qnl_pkg::SumW-1:0] sum_d;

  assign t_d = (blend_i > 16'(qnl_pkg::BlendOne)) ? 16'(qnl_pkg::BlendOne) : blend_i;

  always_comb begin
    logic signed [33:0] dp;
    dp = '0;
    for (int i = 0; i < 4; i++) begin
      dp = dp + 34'(p1_q[i]);
    end
    neg_d = dp[33];
  end

  always_comb begin
    logic [16:0]        omt;
    logic signed [33:0] sx, ex, ox, tx;
    omt = 17'(qnl_pkg::BlendOne) - {1'b0, t2_q};
    ox  = 34'($signed({1'b0, omt}));
    tx  = 34'($signed({2'b0, t2_q}));
    for (int i = 0; i < 4; i++) begin
      sx     = 34'(s2_q[i]);
      ex     = 34'(e2_q[i]);
      a_d[i] = sx * ox;
      b_d[i] = ex * tx;
    end
  end

  always_comb begin
    logic signed [33:0] l;
    for (int i = 0; i < 4; i++) begin
      l        = a3_q[i] + (neg3_q ? -b3_q[i] : b3_q[i]);
      sgn_d[i] = l[33];
      mag_d[i] = l[33] ? qnl_pkg::MagW'(-l) : qnl_pkg::MagW'(l);
    end
  end

  // The shift is the largest one that keeps the biggest magnitude at or
  // below 2^30, which is 30 minus the bit length of (big - 1).
  always_comb begin
    qnl_pkg::mag_t bm1;
    logic [4:0]    len;
    big_d = '0;
    for (int i = 0; i < 4; i++) begin
      if (mag4_q[i] > big_d) begin
        big_d = mag4_q[i];
      end
    end
    bm1 = big_d - 1'b1;
    len = '0;
    for (int b = 0; b < 31; b++) begin
      if (bm1[b]) begin
        len = 5'(b + 1);
      end
    end
    k_d = 5'd30 - len;
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < 4; i++) begin
      sum_d = sum_d + qnl_pkg::SumW'(sq7_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 4; i++) begin
        s1_q[i]   <= s_i[i];
        e1_q[i]   <= e_i[i];
        p1_q[i]   <= s_i[i] * e_i[i];
        s2_q[i]   <= s1_q[i];
        e2_q[i]   <= e1_q[i];
        a3_q[i]   <= a_d[i];
        b3_q[i]   <= b_d[i];
        mag4_q[i] <= mag_d[i];
        mag5_q[i] <= mag4_q[i];
        m6_q[i]   <= mag5_q[i] << k5_q;
        m7_q[i]   <= m6_q[i];
        sq7_q[i]  <= 62'(m6_q[i]) * 62'(m6_q[i]);
        lanes_q.m[i] <= m7_q[i];
      end
      t1_q    <= t_d;
      t2_q    <= t1_q;
      neg2_q  <= neg_d;
      neg3_q  <= neg2_q;
      sgn4_q  <= sgn_d;
      sgn5_q  <= sgn4_q;
      k5_q    <= k_d;
      zero5_q <= (big_d == '0);
      sgn6_q  <= sgn5_q;
      zero6_q <= zero5_q;
      sgn7_q  <= sgn6_q;
      zero7_q <= zero6_q;
      lanes_q.sgn  <= sgn7_q;
      lanes_q.zero <= zero7_q;
      sum_q   <= sum_d;
    end
  end

  assign valid_o = v_q[7];
  assign lanes_o = lanes_q;
  assign sum_o   = sum_q;
endmodule

### sv/qnl_sqrt.sv
// Pipelined integer square root, two result bits per register stage.
// Depends on qnl_pkg. The lane data travels alongside unchanged.
module qnl_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  qnl_pkg::lanes_t           lanes_i,
  input  logic [qnl_pkg::SumW-1:0]  sum_i,
  output logic                      valid_o,
  output qnl_pkg::lanes_t           lanes_o,
  output logic [qnl_pkg::RootW-1:0] root_o
);
  localparam int unsigned N = qnl_pkg::SqrtStages;

  logic                      v_s   [N+1];
  qnl_pkg::lanes_t           l_s   [N+1];
  logic [qnl_pkg::SumW-1:0]  n_s   [N+1];
  logic [qnl_pkg::ResW-1:0]  r_s   [N+1];

  assign v_s[0] = valid_i;
  assign l_s[0] = lanes_i;
  assign n_s[0] = sum_i;
  assign r_s[0] = '0;

  for (genvar j = 0; j < N; j++) begin : g_stage
    logic [qnl_pkg::SumW-1:0] n_d;
    logic [qnl_pkg::ResW-1:0] r_d;

    always_comb begin
      logic [qnl_pkg::ResW-1:0] b;
      logic [qnl_pkg::ResW-1:0] t;
      n_d = n_s[j];
      r_d = r_s[j];
      for (int i = 0; i < qnl_pkg::SqrtPer; i++) begin
        b = qnl_pkg::ResW'(1) << (62 - 2 * (qnl_pkg::SqrtPer * j + i));
        t = r_d + b;
        if (qnl_pkg::ResW'(n_d) >= t) begin
          n_d = n_d - qnl_pkg::SumW'(t);
          r_d = (r_d >> 1) + b;
        end else begin
          r_d = r_d >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[j+1] <= 1'b0;
      end else if (adv_i) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        l_s[j+1] <= l_s[j];
        n_s[j+1] <= n_d;
        r_s[j+1] <= r_d;
      end
    end
  end

  assign valid_o = v_s[N];
  assign lanes_o = l_s[N];
  assign root_o  = qnl_pkg::RootW'(r_s[N]);
endmodule

### sv/qnl_div.sv
// Four pipelined restoring dividers that scale each lane by 2^14 / root.
// Depends on qnl_pkg. One setup stage, then three quotient bits per stage.
module qnl_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic                      valid_i,
  input  qnl_pkg::lanes_t           lanes_i,
  input  logic [qnl_pkg::RootW-1:0] root_i,
  output logic                      valid_o,
  output logic [qnl_pkg::QW-1:0]    q_o [4],
  output logic [3:0]                sgn_o,
  output logic                      zero_o
);
  localparam int unsigned N = qnl_pkg::DivStages;

  typedef struct packed {
    logic [3:0][qnl_pkg::RemW-1:0] rem;
    logic [3:0][qnl_pkg::QW-1:0]   q;
    logic [qnl_pkg::RootW:0]       d;
    logic [3:0]                    sgn;
    logic                          zero;
  } div_t;

  logic v_s [N+1];
  div_t x_s [N+1];

  // Rounded quotient: (2*num + root) / (2*root) with num = m * 2^14.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s[0] <= 1'b0;
    end else if (adv_i) begin
      v_s[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 4; i++) begin
        x_s[0].rem[i] <= {2'b0, lanes_i.m[i], 15'b0} + qnl_pkg::RemW'(root_i);
        x_s[0].q[i]   <= '0;
      end
      x_s[0].d    <= {root_i, 1'b0};
      x_s[0].sgn  <= lanes_i.sgn;
      x_s[0].zero <= lanes_i.zero;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_stage
    div_t x_d;

    always_comb begin
      logic [qnl_pkg::RemW-1:0] sh;
      x_d = x_s[j];
      for (int i = 0; i < qnl_pkg::DivPer; i++) begin
        sh = qnl_pkg::RemW'(x_s[j].d) << (qnl_pkg::QW - 1 - (qnl_pkg::DivPer * j + i));
        for (int l = 0; l < 4; l++) begin
          if (x_d.rem[l] >= sh) begin
            x_d.rem[l] = x_d.rem[l] - sh;
            x_d.q[l][qnl_pkg::QW-1-(qnl_pkg::DivPer*j+i)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[j+1] <= 1'b0;
      end else if (adv_i) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_s[j+1] <= x_d;
      end
    end
  end

  assign valid_o = v_s[N];
  for (genvar l = 0; l < 4; l++) begin : g_q
    assign q_o[l] = x_s[N].q[l];
  end
  assign sgn_o  = x_s[N].sgn;
  assign zero_o = x_s[N].zero;
endmodule
